### rtl/eds_pkg.sv
// Shared constants and types for the edit distance block.
`timescale 1ns / 1ps
package eds_pkg;

	localparam int MAX_LEN  = 64;
	localparam int LEN_W    = $clog2(MAX_LEN + 1);
	localparam int A_AW     = $clog2(MAX_LEN);
	localparam int DP_DEPTH = MAX_LEN + 1;
	localparam int CHAR_W   = 8;
	localparam int OP_W     = 2;
	localparam int DIST_W   = 7;
	localparam int SIM_W    = 16;
	localparam int FRAC_W   = 15;
	localparam int STEP_W   = $clog2(FRAC_W);

	localparam logic [SIM_W-1:0] SIM_ONE = SIM_W'(1) << FRAC_W;

	typedef enum logic [OP_W-1:0] {
		OP_START    = 2'd0,
		OP_APPEND_A = 2'd1,
		OP_APPEND_B = 2'd2,
		OP_FINISH   = 2'd3
	} op_t;

endpackage

### rtl/eds_if.sv
// Request and result channel interfaces for the edit distance block.
`timescale 1ns / 1ps
interface eds_req_if import eds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [OP_W-1:0]   opcode;
	logic [CHAR_W-1:0] char_code;

	modport source (output valid, output opcode, output char_code, input ready);
	modport sink (input valid, input opcode, input char_code, output ready);
endinterface

interface eds_res_if import eds_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DIST_W-1:0] distance;
	logic [SIM_W-1:0]  similarity;
	logic              error;

	modport source (output valid, output distance, output similarity, output error,
		input ready);
	modport sink (input valid, input distance, input similarity, input error,
		output ready);
endinterface

### rtl/edit_distance_similarity.sv
// Edit distance: start, append A and a dropped byte are handled in the idle state; a B byte sweeps the DP row once.
// B byte: one row cell per cycle through the DP read port;
// the first B byte first loads the initial row (ST_LOAD).
// Finish: the request passes ST_FIN_RD, ST_FIN_CHK, the bit-serial Q1.15 divider (ST_DIV) only when
// a division is needed, and ST_FIN_OUT. One request at a time; a result waits in its output register.
// Reset clears lengths, flags and the sequencer; the A string and DP row memories are not cleared.
`timescale 1ns / 1ps
module edit_distance_similarity import eds_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	eds_req_if.sink    req,
	eds_res_if.source  res
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SWEEP,
		ST_FIN_RD,
		ST_FIN_CHK,
		ST_DIV,
		ST_FIN_OUT
	} state_t;

	state_t state_q;

	logic [CHAR_W-1:0] str_mem [MAX_LEN];
	logic [LEN_W-1:0]  dp_mem [DP_DEPTH];

	logic [LEN_W-1:0]  len_a_q, len_b_q;
	logic              b_started_q, error_q;
	logic [CHAR_W-1:0] ch_q;
	logic [LEN_W-1:0]  cnt_q;
	logic              issue_q;
	logic              vld_s1;
	logic [LEN_W-1:0]  idx_s1;
	logic [LEN_W-1:0]  diag_q, left_q;
	logic [LEN_W-1:0]  dist_q, rem_q, div_m_q;
	logic [SIM_W-1:0]  sim_q;
	logic [STEP_W-1:0] step_q;

	logic              res_valid_q;
	logic [DIST_W-1:0] res_dist_q;
	logic [SIM_W-1:0]  res_sim_q;
	logic              res_err_q;

	logic [CHAR_W-1:0] str_rd_q;
	logic [LEN_W-1:0]  dp_rd_q;

	logic              req_fire;
	logic              str_we;
	logic [LEN_W-1:0]  cnt_m1;
	logic [LEN_W-1:0]  dp_raddr;
	logic              dp_we;
	logic [LEN_W-1:0]  dp_waddr, dp_wdata;
	logic [LEN_W:0]    up_inc, left_inc, diag_c, min_ab, min_abc;
	logic [LEN_W-1:0]  cell_new;
	logic [LEN_W-1:0]  lb_inc;
	logic [LEN_W-1:0]  fin_d, fin_m;
	logic [LEN_W:0]    rem_x2;
	logic              div_ge;
	logic [LEN_W-1:0]  rem_nxt;

	assign req.ready = (state_q == ST_IDLE);
	assign req_fire  = req.valid && req.ready;

	assign res.valid      = res_valid_q;
	assign res.distance   = res_dist_q;
	assign res.similarity = res_sim_q;
	assign res.error      = res_err_q;

	assign str_we = req_fire && (op_t'(req.opcode) == OP_APPEND_A) && !b_started_q &&
		(len_a_q < LEN_W'(MAX_LEN));
	assign cnt_m1   = cnt_q - 1'b1;
	assign dp_raddr = (state_q == ST_FIN_RD) ? len_a_q : cnt_q;
	assign lb_inc   = len_b_q + 1'b1;

	// one DP cell: min of up+1, left+1, diag+cost
	always_comb begin
		up_inc   = {1'b0, dp_rd_q} + 1'b1;
		left_inc = {1'b0, left_q} + 1'b1;
		diag_c   = {1'b0, diag_q} + ((str_rd_q == ch_q) ? 1'b0 : 1'b1);
		min_ab   = (left_inc < up_inc) ? left_inc : up_inc;
		min_abc  = (diag_c < min_ab) ? diag_c : min_ab;
		cell_new = min_abc[LEN_W-1:0];
	end

	always_comb begin
		dp_we    = 1'b0;
		dp_waddr = cnt_q;
		dp_wdata = cnt_q;
		unique case (state_q)
			ST_LOAD: begin
				dp_we = 1'b1;
			end
			ST_SWEEP: begin
				dp_we    = vld_s1;
				dp_waddr = idx_s1;
				dp_wdata = (idx_s1 == '0) ? lb_inc : cell_new;
			end
			default: begin
				dp_we = 1'b0;
			end
		endcase
	end

	always_comb begin
		fin_d  = b_started_q ? dp_rd_q : len_a_q;
		fin_m  = (len_a_q > len_b_q) ? len_a_q : len_b_q;
		rem_x2 = {rem_q, 1'b0};
		div_ge = (rem_x2 >= {1'b0, div_m_q});
		rem_nxt = div_ge ? LEN_W'(rem_x2 - {1'b0, div_m_q}) : LEN_W'(rem_x2);
	end

	always_ff @(posedge clk) begin
		if (str_we) begin
			str_mem[len_a_q[A_AW-1:0]] <= req.char_code;
		end
		str_rd_q <= str_mem[cnt_m1[A_AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (dp_we) begin
			dp_mem[dp_waddr] <= dp_wdata;
		end
		dp_rd_q <= dp_mem[dp_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_a_q     <= '0;
			len_b_q     <= '0;
			b_started_q <= 1'b0;
			error_q     <= 1'b0;
			cnt_q       <= '0;
			issue_q     <= 1'b0;
			vld_s1      <= 1'b0;
			step_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (res_valid_q && res.ready) begin
				res_valid_q <= 1'b0;
			end
			vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_fire) begin
						ch_q <= req.char_code;
						unique case (op_t'(req.opcode))
							OP_START: begin
								len_a_q     <= '0;
								len_b_q     <= '0;
								b_started_q <= 1'b0;
								error_q     <= 1'b0;
							end
							OP_APPEND_A: begin
								if (str_we) begin
									len_a_q <= len_a_q + 1'b1;
								end else begin
									error_q <= 1'b1;
								end
							end
							OP_APPEND_B: begin
								cnt_q <= '0;
								if (!b_started_q) begin
									state_q <= ST_LOAD;
								end else if (len_b_q >= LEN_W'(MAX_LEN)) begin
									error_q <= 1'b1;
								end else begin
									issue_q <= 1'b1;
									state_q <= ST_SWEEP;
								end
							end
							OP_FINISH: begin
								state_q <= ST_FIN_RD;
							end
						endcase
					end
				end
				ST_LOAD: begin
					if (cnt_q == len_a_q) begin
						b_started_q <= 1'b1;
						cnt_q       <= '0;
						if (len_b_q >= LEN_W'(MAX_LEN)) begin
							error_q <= 1'b1;
							state_q <= ST_IDLE;
						end else begin
							issue_q <= 1'b1;
							state_q <= ST_SWEEP;
						end
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_SWEEP: begin
					// issue reads one cell ahead of the write-back
					if (issue_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= cnt_q;
						if (cnt_q == len_a_q) begin
							issue_q <= 1'b0;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
					if (vld_s1) begin
						diag_q <= dp_rd_q;
						left_q <= (idx_s1 == '0) ? lb_inc : cell_new;
						if (idx_s1 == len_a_q) begin
							len_b_q <= lb_inc;
							vld_s1  <= 1'b0;
							state_q <= ST_IDLE;
						end
					end
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN_CHK;
				end
				ST_FIN_CHK: begin
					dist_q <= fin_d;
					if (fin_m == '0) begin
						sim_q   <= SIM_ONE;
						state_q <= ST_FIN_OUT;
					end else if (fin_d >= fin_m) begin
						sim_q   <= '0;
						state_q <= ST_FIN_OUT;
					end else if (fin_d == '0) begin
						sim_q   <= SIM_ONE;
						state_q <= ST_FIN_OUT;
					end else begin
						rem_q   <= fin_m - fin_d;
						div_m_q <= fin_m;
						sim_q   <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit per cycle
					rem_q <= rem_nxt;
					sim_q <= {sim_q[SIM_W-2:0], div_ge};
					if (step_q == STEP_W'(FRAC_W - 1)) begin
						state_q <= ST_FIN_OUT;
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_FIN_OUT: begin
					if (!res_valid_q || res.ready) begin
						res_valid_q <= 1'b1;
						res_dist_q  <= DIST_W'(dist_q);
						res_sim_q   <= sim_q;
						res_err_q   <= error_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### bench/edit_distance_similarity_tb.sv
// Self-checking bench for the edit distance block: request driver, result monitor, predictor.
`timescale 1ns / 1ps
module edit_distance_similarity_tb import eds_pkg::*; ();

	localparam int ITEM_GOAL   = 1450;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_WAIT  = 200;

	typedef struct {
		op_t               op;
		logic [CHAR_W-1:0] ch;
		bit                drain_first;
	} edit_req_t;

	typedef struct {
		logic [DIST_W-1:0] distance;
		logic [SIM_W-1:0]  similarity;
		logic              error;
	} score_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	eds_req_if req_if ();
	eds_res_if res_if ();

	edit_distance_similarity dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.res    (res_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	edit_req_t req_q[$];
	score_t    score_q[$];
	int        fail_count = 0;
	int        cycle_count = 0;
	bit        req_taken = 1'b0;

	// Predictor state
	logic [CHAR_W-1:0] str_a[MAX_LEN];
	int                row[DP_DEPTH];
	int                len_a = 0;
	int                len_b = 0;
	bit                b_seen = 1'b0;
	bit                err_seen = 1'b0;

	function automatic int min_of3(int p, int q, int r);
		int m;
		m = p;
		if (q < m) m = q;
		if (r < m) m = r;
		return m;
	endfunction

	// Apply one request to the predictor; returns 1 when it yields a score.
	function automatic bit predict_edit(input op_t op, input logic [CHAR_W-1:0] ch,
		output score_t sc);
		int diag;
		int up;
		int d;
		int m;
		longint unsigned sim;
		sc = '{default: '0};
		case (op)
			OP_START: begin
				len_a = 0;
				len_b = 0;
				b_seen = 1'b0;
				err_seen = 1'b0;
				return 1'b0;
			end
			OP_APPEND_A: begin
				if (b_seen || len_a >= MAX_LEN) begin
					err_seen = 1'b1;
				end else begin
					str_a[len_a] = ch;
					len_a++;
				end
				return 1'b0;
			end
			OP_APPEND_B: begin
				if (!b_seen) begin
					for (int j = 0; j <= len_a; j++) row[j] = j;
					b_seen = 1'b1;
				end
				if (len_b >= MAX_LEN) begin
					err_seen = 1'b1;
				end else begin
					diag = row[0];
					row[0] = len_b + 1;
					for (int y = 1; y <= len_a; y++) begin
						up = row[y];
						row[y] = min_of3(up + 1, row[y-1] + 1,
							diag + ((str_a[y-1] == ch) ? 0 : 1));
						diag = up;
					end
					len_b++;
				end
				return 1'b0;
			end
			default: begin
				d = b_seen ? row[len_a] : len_a;
				m = (len_a > len_b) ? len_a : len_b;
				if (m == 0)
					sim = 32768;
				else if (d >= m)
					sim = 0;
				else
					sim = (longint'(m - d) * 32768) / m;
				sc.distance = DIST_W'(d);
				sc.similarity = SIM_W'(sim);
				sc.error = err_seen;
				return 1'b1;
			end
		endcase
	endfunction

	task automatic note_failure(input string what);
		if (fail_count < 10)
			$display("[%0t] mismatch: %s", $time, what);
		fail_count++;
	endtask

	// Monitor: predict on accepted requests, check accepted results.
	always @(posedge clk) begin
		score_t sc;
		score_t want;
		if (arst_n) begin
			if (req_if.valid && req_if.ready) begin
				req_taken = 1'b1;
				if (predict_edit(op_t'(req_if.opcode), req_if.char_code, sc))
					score_q.push_back(sc);
			end
			if (res_if.valid && res_if.ready) begin
				if (score_q.size() == 0) begin
					note_failure($sformatf("unexpected result dist=%0d sim=%0d err=%0b",
						res_if.distance, res_if.similarity, res_if.error));
				end else begin
					want = score_q.pop_front();
					if (res_if.distance !== want.distance ||
						res_if.similarity !== want.similarity ||
						res_if.error !== want.error)
						note_failure($sformatf(
							"expected dist=%0d sim=%0d err=%0b, got dist=%0d sim=%0d err=%0b",
							want.distance, want.similarity, want.error,
							res_if.distance, res_if.similarity, res_if.error));
				end
			end
		end
	end

	// Driver: bursts of requests with random gaps, changes on the falling edge.
	int burst_left = 1;
	int gap_left = 0;

	always @(negedge clk) begin
		edit_req_t it;
		if (arst_n && !(req_if.valid && !req_taken)) begin
			if (gap_left > 0) begin
				gap_left--;
				req_if.valid <= 1'b0;
				req_if.opcode <= OP_W'($urandom);
				req_if.char_code <= CHAR_W'($urandom);
			end else if (req_q.size() != 0 &&
				!(req_q[0].drain_first && score_q.size() != 0)) begin
				it = req_q.pop_front();
				req_if.valid <= 1'b1;
				req_if.opcode <= it.op;
				req_if.char_code <= it.ch;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 40);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
				end
			end else begin
				req_if.valid <= 1'b0;
			end
		end
		req_taken = 1'b0;
	end

	// Receiver: stall pattern switches among always-ready, coin-flip and mostly-stalled.
	int rx_mode = 0;
	int rx_left = 50;

	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_left == 0) begin
				rx_mode = $urandom_range(0, 2);
				rx_left = $urandom_range(20, 200);
			end else begin
				rx_left--;
			end
			case (rx_mode)
				0:       res_if.ready <= 1'b1;
				1:       res_if.ready <= 1'($urandom_range(0, 1));
				default: res_if.ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_req(input op_t op, input int ch, input bit drain = 1'b0);
		edit_req_t it;
		it.op = op;
		it.ch = CHAR_W'(ch);
		it.drain_first = drain;
		req_q.push_back(it);
	endtask

	function automatic int pick_char(input int alpha);
		case (alpha)
			0:       return "abAB" >> (8 * $urandom_range(0, 3));
			1:       return $urandom_range(0, 255);
			default: return "a" + $urandom_range(0, 7);
		endcase
	endfunction

	function automatic int pick_len();
		return ($urandom_range(0, 9) < 8) ? $urandom_range(0, 9) : $urandom_range(0, MAX_LEN);
	endfunction

	task automatic push_comparison(input int la, input int lb, input int alpha);
		push_req(OP_START, $urandom_range(0, 255));
		for (int i = 0; i < la; i++) push_req(OP_APPEND_A, pick_char(alpha));
		for (int i = 0; i < lb; i++) push_req(OP_APPEND_B, pick_char(alpha));
		push_req(OP_FINISH, $urandom_range(0, 255));
	endtask

	initial begin
		int kind;
		int n;
		req_if.valid = 1'b0;
		req_if.opcode = OP_START;
		req_if.char_code = '0;
		res_if.ready = 1'b0;

		// Directed: empty strings, byte extremes, finish without B, A after B,
		// reporting twice, case sensitivity, empty A, identical strings.
		push_req(OP_START, 8'h00);
		push_req(OP_FINISH, 8'h00);
		push_req(OP_APPEND_A, 8'h00);
		push_req(OP_APPEND_A, 8'hFF);
		push_req(OP_FINISH, 8'h00);
		push_req(OP_APPEND_B, 8'hFF);
		push_req(OP_APPEND_B, "q");
		push_req(OP_FINISH, 8'h00);
		push_req(OP_APPEND_A, "z");
		push_req(OP_FINISH, 8'h00);
		push_req(OP_APPEND_B, 8'h00);
		push_req(OP_FINISH, 8'hFF);
		push_req(OP_START, 8'hFF);
		push_req(OP_APPEND_A, "a");
		push_req(OP_APPEND_A, "B");
		push_req(OP_APPEND_B, "A");
		push_req(OP_APPEND_B, "B");
		push_req(OP_FINISH, 8'hAA);
		push_req(OP_START, 8'h55);
		push_req(OP_APPEND_B, "x");
		push_req(OP_FINISH, 8'h55);
		push_req(OP_START, 8'h00);
		push_req(OP_APPEND_A, "k");
		push_req(OP_APPEND_B, "k");
		push_req(OP_FINISH, 8'h00);

		// Full-length strings with nothing in common, then both overflows.
		push_req(OP_START, 8'h00, 1'b1);
		for (int i = 0; i < MAX_LEN; i++) push_req(OP_APPEND_A, "a");
		for (int i = 0; i < MAX_LEN; i++) push_req(OP_APPEND_B, "b");
		push_req(OP_FINISH, 8'h00);
		push_comparison(MAX_LEN + 2, 3, 0);
		push_comparison(2, MAX_LEN + 2, 2);

		while (req_q.size() < ITEM_GOAL) begin
			kind = $urandom_range(0, 99);
			if (kind < 75) begin
				push_comparison(pick_len(), pick_len(), $urandom_range(0, 2));
				n = $urandom_range(0, 9);
				if (n == 0) begin
					push_req(OP_APPEND_A, pick_char(1));
					push_req(OP_FINISH, pick_char(1));
				end else if (n == 1) begin
					push_req(OP_APPEND_B, pick_char(0));
					push_req(OP_FINISH, pick_char(1));
				end else if (n == 2) begin
					push_req(OP_FINISH, pick_char(1));
				end
			end else if (kind < 85) begin
				// Extend the current comparison without a restart.
				n = $urandom_range(1, 4);
				for (int i = 0; i < n; i++)
					push_req(op_t'($urandom_range(1, 2)), pick_char(0));
				push_req(OP_FINISH, pick_char(1));
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					push_req(op_t'($urandom_range(0, 3)), pick_char(1));
			end
			// Hold off now and then until every pending score has come back.
			if ($urandom_range(0, 49) == 0 && req_q.size() > 0)
				req_q[req_q.size() - 1].drain_first = 1'b1;
		end

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (req_q.size() != 0 || req_if.valid) @(posedge clk);
		while (score_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (score_q.size() != 0)
			note_failure("scores still outstanding at end of run");

		if (fail_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
